FILE: sv/cq_rm_pkg.sv
package cq_rm_pkg;

    localparam int DEPTH_DEF       = 16;
    localparam int ENTRY_WIDTH_DEF = 32;

    // count and position domain wide enough for the largest depth (256)
    localparam int CNT_W = 9;

    localparam int CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
    localparam logic [OP_W-1:0] OP_POP    = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
    localparam logic [OP_W-1:0] OP_PEEK   = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAN  = 3'd4;

    // broadcast to every cell for one transaction
    typedef struct packed {
        logic             clean;     // zero the word
        logic             append;    // load the write value if index == count
        logic             collapse;  // take neighbor word in [cpos, count-2]
        logic [CNT_W-1:0] count;     // count before the transaction
        logic [CNT_W-1:0] cpos;      // first position that collapses
    } t_cell_ctl;

endpackage

FILE: sv/collapsing_queue_with_remove.sv
// Collapsing queue with remove-at-position.
// Input stream s_axis carries one command per transaction (append, pop head,
// remove at position, peek at position, clean); output stream m_axis returns
// exactly one status transaction per command: done flag, peek data, count
// after the command, empty and full.
// The store is a chain of DEPTH cells; each cell loads, clears, holds or
// takes its upper neighbor's word in the same cycle, so a pop or remove
// closes the gap by moving every later word down together.
// The status is registered and appears on m_axis in the cycle after the
// command is accepted. The queue takes one command per clock while m_axis
// is ready or holds no status, as the cell chain and count update together.
// Stall: the output register frees s_axis_tready whenever it is empty or
// being taken, so a stalled receiver holds at most one status and stops
// further commands until it drains.
// Reset (i_rst_n low, synchronous): all cells and the count go to zero,
// capacity returns to 16, the output register is emptied.
// Capacity is written via i_cfg_wr_en / i_cfg_wr_data, by the user only
// while idle, unchecked; above DEPTH acts as DEPTH, zero keeps it full.
module collapsing_queue_with_remove #(
    parameter int DEPTH       = cq_rm_pkg::DEPTH_DEF,
    parameter int ENTRY_WIDTH = cq_rm_pkg::ENTRY_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [cq_rm_pkg::CAP_W-1:0] i_cfg_wr_data,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // [2:0] operation, [34:3] entry_value, [38:35] position, [39] zero
    input  logic [39:0]                s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // [0] done_res, [32:1] read_data, [37:33] entry_count, [38] is_empty,
    // [39] is_full
    output logic [39:0]                m_axis_tdata
);
    import cq_rm_pkg::*;

    localparam int CW     = $clog2(DEPTH + 1);
    localparam int PEEK_N = (DEPTH < 16) ? DEPTH : 16;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    // command fields
    logic [OP_W-1:0]        op;
    logic [31:0]            in_value;
    logic [3:0]             pos;
    logic [ENTRY_WIDTH-1:0] wr_value;

    assign op       = s_axis_tdata[2:0];
    assign in_value = s_axis_tdata[34:3];
    assign pos      = s_axis_tdata[38:35];

    generate
        if (ENTRY_WIDTH <= 32) begin : g_win_trunc
            assign wr_value = in_value[ENTRY_WIDTH-1:0];
        end else begin : g_win_ext
            assign wr_value = {{(ENTRY_WIDTH-32){1'b0}}, in_value};
        end
    endgenerate

    // state
    logic [CAP_W-1:0] r_cap;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic             r_out_valid;
    logic [39:0]      r_out_data;
    logic [39:0]      n_out_data;

    logic accept;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // cell chain
    logic [ENTRY_WIDTH-1:0] words [DEPTH];
    t_cell_ctl              ctl;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [ENTRY_WIDTH-1:0] next_word;
            if (gi == DEPTH - 1) begin : g_last
                assign next_word = '0;
            end else begin : g_mid
                assign next_word = words[gi+1];
            end
            cq_rm_cell #(
                .ENTRY_WIDTH(ENTRY_WIDTH),
                .INDEX      (gi)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (ctl),
                .i_wr_value (wr_value),
                .i_next_word(next_word),
                .o_word     (words[gi])
            );
        end
    endgenerate

    // command decode
    logic [CNT_W-1:0]       cnt;
    logic [CNT_W-1:0]       cap;
    logic [CNT_W-1:0]       pos_w;
    logic [CNT_W-1:0]       new_cnt;
    logic                   full_now;
    logic                   done;
    logic                   peek_ok;
    logic [ENTRY_WIDTH-1:0] peek_word;
    logic [31:0]            rd_data;

    assign cnt      = CNT_W'(r_count);
    assign cap      = CNT_W'(r_cap);
    assign pos_w    = CNT_W'(pos);
    assign full_now = (cnt >= cap) || (cnt >= DEPTH_C);

    // peek mux: the 4-bit position reaches at most the first 16 cells
    always_comb begin
        peek_word = '0;
        for (int j = 0; j < PEEK_N; j++) begin
            if (pos == 4'(j)) begin
                peek_word = words[j];
            end
        end
    end

    always_comb begin
        ctl          = '0;
        ctl.count    = cnt;
        ctl.cpos     = '0;
        done         = 1'b0;
        peek_ok      = 1'b0;
        new_cnt      = cnt;
        unique case (op)
            OP_APPEND: begin
                if (!full_now) begin
                    ctl.append = accept;
                    new_cnt    = cnt + 1'b1;
                    done       = 1'b1;
                end
            end
            OP_POP: begin
                if (cnt != '0) begin
                    ctl.collapse = accept;
                    new_cnt      = cnt - 1'b1;
                    done         = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (pos_w < cnt) begin
                    ctl.collapse = accept;
                    ctl.cpos     = pos_w;
                    new_cnt      = cnt - 1'b1;
                    done         = 1'b1;
                end
            end
            OP_PEEK: begin
                if ((cnt != '0) && (pos_w < DEPTH_C)) begin
                    peek_ok = 1'b1;
                    done    = 1'b1;
                end
            end
            OP_CLEAN: begin
                ctl.clean = accept;
                new_cnt   = '0;
                done      = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign n_count = accept ? CW'(new_cnt) : r_count;

    generate
        if (ENTRY_WIDTH >= 32) begin : g_rd_trunc
            assign rd_data = peek_ok ? peek_word[31:0] : 32'd0;
        end else begin : g_rd_ext
            assign rd_data = peek_ok ? {{(32-ENTRY_WIDTH){1'b0}}, peek_word} : 32'd0;
        end
    endgenerate

    always_comb begin
        n_out_data        = '0;
        n_out_data[0]     = done;
        n_out_data[32:1]  = rd_data;
        n_out_data[37:33] = new_cnt[4:0];
        n_out_data[38]    = (new_cnt == '0);
        n_out_data[39]    = (new_cnt >= cap) || (new_cnt >= DEPTH_C);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

FILE: sv/cq_rm_cell.sv
module cq_rm_cell #(
    parameter int ENTRY_WIDTH = cq_rm_pkg::ENTRY_WIDTH_DEF,
    parameter int INDEX       = 0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  cq_rm_pkg::t_cell_ctl   i_ctl,
    input  logic [ENTRY_WIDTH-1:0] i_wr_value,
    input  logic [ENTRY_WIDTH-1:0] i_next_word,
    output logic [ENTRY_WIDTH-1:0] o_word
);
    import cq_rm_pkg::*;

    localparam logic [CNT_W-1:0] IDX      = CNT_W'(INDEX);
    localparam logic [CNT_W-1:0] IDX_NEXT = CNT_W'(INDEX + 1);

    logic [ENTRY_WIDTH-1:0] r_word;
    logic [ENTRY_WIDTH-1:0] n_word;

    always_comb begin
        n_word = r_word;
        if (i_ctl.clean) begin
            n_word = '0;
        end else if (i_ctl.append && (i_ctl.count == IDX)) begin
            n_word = i_wr_value;
        end else if (i_ctl.collapse && (IDX >= i_ctl.cpos) && (IDX_NEXT < i_ctl.count)) begin
            n_word = i_next_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
        end else begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule
